/* rtl/core/cfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants for the CAN frame reassembler: buffer sizing,
// byte-lane banking, result status codes and the lane command structs.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // message buffer sizing
  localparam int MAX_PAYLOAD = 256;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = ADDR_W + 1;

  // byte lanes: one buffer bank per lane, interleaved on the low address bits
  localparam int LANES     = 8;
  localparam int LANE_W    = $clog2(LANES);
  localparam int ROWS      = MAX_PAYLOAD / LANES;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int PAY_BYTES = 7;
  localparam int PLEN_W    = 3;

  // sequence tracking
  localparam int SEQ_W   = 8;
  localparam int SEQ_SAT = 128;

  // frame length limits
  localparam logic [3:0] FLEN_MIN = 4'd2;
  localparam logic [3:0] FLEN_MAX = 4'd8;

  typedef enum logic [2:0] {
    ST_SHORT    = 3'd0,
    ST_ACCEPT   = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_DROP     = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_READ     = 3'd5
  } status_t;

  typedef logic [LANES-1:0][7:0] pay_arr_t;

  // append command broadcast to all lanes
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] base;
    logic [PLEN_W-1:0] plen;
  } wr_cmd_t;

  // read command broadcast to all lanes
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_cmd_t;

endpackage

/* rtl/core/cfr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/cfr_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_lane
// One byte lane of the message buffer. The lane owns the bank that holds
// every buffer address whose low bits equal its lane number, picks its
// payload byte out of an append, and serves reads that fall in its bank.
// ----------------------------------------------------------------------------
module cfr_lane (
  input  logic                     clk,
  input  logic [cfr_pkg::LANE_W-1:0] lane_id,
  input  cfr_pkg::wr_cmd_t         wr,
  input  cfr_pkg::pay_arr_t        pay,
  input  cfr_pkg::rd_cmd_t         rd,
  output logic [7:0]               rd_data
);
  import cfr_pkg::*;

  logic [LANE_W-1:0] offset;
  logic [ADDR_W-1:0] waddr_full;
  logic              we;
  logic [7:0]        wdata;
  logic              re;

  // position of this lane's byte within the appended run
  assign offset     = lane_id - wr.base[LANE_W-1:0];
  assign we         = wr.en && ({1'b0, offset} < {1'b0, wr.plen});
  assign wdata      = pay[offset];
  assign waddr_full = wr.base + ADDR_W'(offset);

  // read hits this lane when the low address bits select it
  assign re = rd.en && (rd.addr[LANE_W-1:0] == lane_id);

  cfr_ram #(
    .WIDTH (8),
    .DEPTH (ROWS)
  ) u_bank (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_full[ADDR_W-1:LANE_W]),
    .wdata (wdata),
    .re    (re),
    .raddr (rd.addr[ADDR_W-1:LANE_W]),
    .rdata (rd_data)
  );

endmodule

/* rtl/core/cfr_session.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_session
// Session tracking for the reassembler: open/close, expected sequence,
// stored length and overflow check. Produces the result status and the
// append command for the byte lanes.
// ----------------------------------------------------------------------------
module cfr_session (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        req_type,
  input  logic [3:0]                  frame_len,
  input  logic [7:0]                  header_byte,
  input  logic [7:0]                  read_index,
  output cfr_pkg::wr_cmd_t            wr,
  output cfr_pkg::status_t            status,
  output logic [cfr_pkg::LEN_W-1:0]   msg_len,
  output logic                        rd_hit
);
  import cfr_pkg::*;

  logic              active;
  logic              active_next;
  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  length_next;
  logic [SEQ_W-1:0]  exp_seq;
  logic [SEQ_W-1:0]  exp_seq_next;

  logic [3:0]        flen_c;
  logic [PLEN_W-1:0] plen;
  logic [6:0]        seq;
  logic              last;
  logic              opening;
  logic              eff_active;
  logic [LEN_W-1:0]  eff_len;
  logic [SEQ_W-1:0]  eff_exp;
  logic [LEN_W:0]    sum;
  logic              do_write;

  // header decode and length clamp
  assign flen_c  = (frame_len > FLEN_MAX) ? FLEN_MAX : frame_len;
  assign plen    = PLEN_W'(flen_c - 4'd1);
  assign seq     = header_byte[6:0];
  assign last    = header_byte[7];
  assign opening = (seq == 7'd0);

  // a sequence-zero frame starts from a fresh session
  assign eff_active = opening ? 1'b1 : active;
  assign eff_len    = opening ? '0 : length;
  assign eff_exp    = opening ? '0 : exp_seq;
  assign sum        = {1'b0, eff_len} + (LEN_W+1)'(plen);

  // next state and status
  always_comb begin
    active_next  = active;
    length_next  = length;
    exp_seq_next = exp_seq;
    status       = ST_READ;
    do_write     = 1'b0;
    if (req_type) begin
      status = ST_READ;
    end else if (frame_len < FLEN_MIN) begin
      status = ST_SHORT;
    end else if (!eff_active || (SEQ_W'(seq) != eff_exp)) begin
      status = ST_DROP;
    end else if (sum > (LEN_W+1)'(MAX_PAYLOAD)) begin
      active_next  = 1'b0;
      length_next  = eff_len;
      exp_seq_next = eff_exp;
      status       = ST_OVERFLOW;
    end else begin
      do_write     = 1'b1;
      length_next  = sum[LEN_W-1:0];
      exp_seq_next = (eff_exp < SEQ_W'(SEQ_SAT)) ? eff_exp + 1'b1 : eff_exp;
      active_next  = !last;
      status       = last ? ST_COMPLETE : ST_ACCEPT;
    end
  end

  // append command for the lanes
  assign wr.en   = accept && do_write;
  assign wr.base = eff_len[ADDR_W-1:0];
  assign wr.plen = plen;

  assign msg_len = length_next;
  assign rd_hit  = (LEN_W'(read_index) < length);

  // session registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      length  <= '0;
      exp_seq <= '0;
    end else if (accept) begin
      active  <= active_next;
      length  <= length_next;
      exp_seq <= exp_seq_next;
    end
  end

endmodule

/* rtl/core/can_frame_reassembler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_reassembler
// Receive-side CAN segment reassembly with a byte-addressable message buffer.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while in_stall is low: either a received
// frame or a read of one buffered byte, and gives exactly one result per
// transaction through the read stage and the output register. The buffer
// is split into eight byte lanes, each a 32-byte bank holding every eighth
// address, so the up to seven payload bytes of a frame land in seven banks
// in a single write cycle. The read stage covers the banks' registered read port.
// A result waiting at the output does not block intake: one more transaction
// is taken into the read stage, and only then does in_stall follow out_stall.
// Buffer contents are not cleared at reset; reads are served only below the
// stored length, and every such byte was written in the current session.
// ----------------------------------------------------------------------------
module can_frame_reassembler (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [3:0] frame_len,
  input  logic [7:0] header_byte,
  input  logic [7:0] payload_0,
  input  logic [7:0] payload_1,
  input  logic [7:0] payload_2,
  input  logic [7:0] payload_3,
  input  logic [7:0] payload_4,
  input  logic [7:0] payload_5,
  input  logic [7:0] payload_6,
  input  logic [7:0] read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [8:0] message_len,
  output logic [7:0] read_byte
);
  import cfr_pkg::*;

  logic                accept;
  logic                s1_advance;
  wr_cmd_t             wr;
  rd_cmd_t             rd;
  pay_arr_t            pay;
  status_t             sess_status;
  logic [LEN_W-1:0]    sess_len;
  logic                sess_hit;
  logic [LANES-1:0][7:0] lane_data;

  logic                s1_valid;
  status_t             s1_status;
  logic [LEN_W-1:0]    s1_len;
  logic                s1_hit;
  logic [LANE_W-1:0]   s1_lane;

  // handshake: the read stage moves on when the output slot is free or leaving
  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;
  assign accept     = in_valid && !in_stall;

  // payload bytes by position, unused top slot tied off
  assign pay[0]         = payload_0;
  assign pay[1]         = payload_1;
  assign pay[2]         = payload_2;
  assign pay[3]         = payload_3;
  assign pay[4]         = payload_4;
  assign pay[5]         = payload_5;
  assign pay[6]         = payload_6;
  assign pay[LANES-1]   = 8'd0;

  assign rd.en   = accept && req_type;
  assign rd.addr = ADDR_W'(read_index);

  cfr_session u_session (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req_type    (req_type),
    .frame_len   (frame_len),
    .header_byte (header_byte),
    .read_index  (read_index),
    .wr          (wr),
    .status      (sess_status),
    .msg_len     (sess_len),
    .rd_hit      (sess_hit)
  );

  // byte lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    cfr_lane u_lane (
      .clk     (clk),
      .lane_id (LANE_W'(g)),
      .wr      (wr),
      .pay     (pay),
      .rd      (rd),
      .rd_data (lane_data[g])
    );
  end

  // read stage: result fields wait here for bank read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= sess_status;
      s1_len    <= sess_len;
      s1_hit    <= req_type && sess_hit;
      s1_lane   <= read_index[LANE_W-1:0];
    end
  end

  // output register: merge lane read data into the result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      status      <= s1_status;
      message_len <= 9'(s1_len);
      read_byte   <= s1_hit ? lane_data[s1_lane] : 8'd0;
    end
  end

endmodule
